>>> rtl/core/xxh_pkg.sv
package xxh_pkg;

  localparam logic [63:0] PR1 = 64'd11400714785074694791;
  localparam logic [63:0] PR2 = 64'd14029467366897019727;
  localparam logic [63:0] PR3 = 64'd1609587929392839161;
  localparam logic [63:0] PR4 = 64'd9650029242287828579;
  localparam logic [63:0] PR5 = 64'd2870177450012600261;

  localparam int unsigned AVAL_SHIFT_A = 33;
  localparam int unsigned AVAL_SHIFT_B = 29;
  localparam int unsigned AVAL_SHIFT_C = 32;

  localparam int unsigned NUM_LANES = 4;

  localparam logic [63:0] LANE_INIT [NUM_LANES] = '{
    PR1 + PR2,
    PR2,
    64'd0,
    64'd0 - PR1
  };

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

>>> rtl/core/xxh_mul.sv
module xxh_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] prod;

  // low 64 bits of a*b: lo*lo, then the two cross terms into the upper half
  always_comb begin
    case (step)
      2'd0: begin
        mx = ra[31:0];
        my = rb[31:0];
      end
      2'd1: begin
        mx = ra[63:32];
        my = rb[31:0];
      end
      default: begin
        mx = ra[31:0];
        my = rb[63:32];
      end
    endcase
    prod = {32'd0, mx} * {32'd0, my};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= 2'(step + 2'd1);
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ra <= a;
      rb <= b;
    end else if (busy) begin
      if (step == 2'd0) begin
        acc <= prod;
      end else begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
    end
  end

  assign p = acc;

endmodule

>>> rtl/core/xxh64_stream_hash.sv
// channel | signals                                  | role
// in      | in_valid, in_ready, data_word, byte_count, last | message words
// out     | out_valid, out_ready, hash               | one digest per message
//
// A word that completes no stripe and is not last is taken without a multiply. Each 64-bit
// multiply runs on one shared 32x32 unit; a stripe fold is 8 of them. Finalize takes the
// short path, or the lane merge (32 bytes or more), then the tail words, the 4-byte step
// and tail bytes, the avalanche and the load of the output register.
// Reset is synchronous; the output register holds the digest under stall while the
// next message streams in; a second finished digest blocks the input until it drains.
module xxh64_stream_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_FOLD_A = 19'h00002,
    S_FOLD_B = 19'h00004,
    S_FIN    = 19'h00008,
    S_MSUM   = 19'h00010,
    S_MRG_A  = 19'h00020,
    S_MRG_B  = 19'h00040,
    S_MRG_C  = 19'h00080,
    S_ADDT   = 19'h00100,
    S_TAIL   = 19'h00200,
    S_T8_A   = 19'h00400,
    S_T8_B   = 19'h00800,
    S_T8_C   = 19'h01000,
    S_T4_A   = 19'h02000,
    S_T4_B   = 19'h04000,
    S_T1_A   = 19'h08000,
    S_T1_B   = 19'h10000,
    S_AV_A   = 19'h20000,
    S_AV_B   = 19'h40000
  } state_t;

  // finished hash waits in h under out_pend with the machine back in idle
  localparam state_t S_OUT = S_IDLE;

  state_t      state;
  logic [63:0] lane [xxh_pkg::NUM_LANES];
  logic [63:0] sbuf [xxh_pkg::NUM_LANES];
  logic [63:0] total;
  logic [4:0]  bufbytes;
  logic [4:0]  i;
  logic [1:0]  k;
  logic        last_pend;
  logic        out_pend;
  logic        issued;
  logic [63:0] h;
  logic [63:0] t;

  logic        accept;
  logic [3:0]  cnt_eff;
  logic [63:0] word_mask;
  logic [5:0]  fill_sum;
  logic [1:0]  rd_idx;
  logic [63:0] buf_rd;
  logic [63:0] lane_rd;
  logic [63:0] lane_rot;
  logic [7:0]  tail_byte;
  logic        is_mul;
  logic        mul_start;
  logic        mul_done;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_p;
  logic        long_path;

  assign in_ready  = (state == S_IDLE) && !out_pend;
  assign accept    = in_valid && in_ready;
  assign cnt_eff   = (!last || byte_count > 4'd8) ? 4'd8 : byte_count;
  assign word_mask = cnt_eff[3] ? '1 : ((64'd1 << {cnt_eff[2:0], 3'b000}) - 64'd1);
  assign fill_sum  = {1'b0, bufbytes} + {2'b00, cnt_eff};
  assign rd_idx    = (state == S_FOLD_A) ? k : i[4:3];
  assign buf_rd    = sbuf[rd_idx];
  assign lane_rd   = lane[k];
  assign tail_byte = 8'(buf_rd >> {i[2:0], 3'b000});
  assign long_path = |total[63:5];
  assign mul_start = is_mul && !issued;

  always_comb begin
    case (k)
      2'd0:    lane_rot = xxh_pkg::rotl64(lane_rd, 1);
      2'd1:    lane_rot = xxh_pkg::rotl64(lane_rd, 7);
      2'd2:    lane_rot = xxh_pkg::rotl64(lane_rd, 12);
      default: lane_rot = xxh_pkg::rotl64(lane_rd, 18);
    endcase
  end

  always_comb begin
    is_mul = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_FOLD_A: begin
        mul_a = buf_rd;
        mul_b = xxh_pkg::PR2;
      end
      S_FOLD_B: begin
        mul_a = xxh_pkg::rotl64(lane_rd + t, 31);
        mul_b = xxh_pkg::PR1;
      end
      S_MRG_A: begin
        mul_a = lane_rd;
        mul_b = xxh_pkg::PR2;
      end
      S_MRG_B, S_T8_B: begin
        mul_a = xxh_pkg::rotl64(t, 31);
        mul_b = xxh_pkg::PR1;
      end
      S_MRG_C: begin
        mul_a = h ^ t;
        mul_b = xxh_pkg::PR1;
      end
      S_T8_A: begin
        mul_a = buf_rd;
        mul_b = xxh_pkg::PR2;
      end
      S_T8_C: begin
        mul_a = xxh_pkg::rotl64(h ^ t, 27);
        mul_b = xxh_pkg::PR1;
      end
      S_T4_A: begin
        mul_a = {32'd0, buf_rd[31:0]};
        mul_b = xxh_pkg::PR1;
      end
      S_T4_B: begin
        mul_a = xxh_pkg::rotl64(h ^ t, 23);
        mul_b = xxh_pkg::PR2;
      end
      S_T1_A: begin
        mul_a = {56'd0, tail_byte};
        mul_b = xxh_pkg::PR5;
      end
      S_T1_B: begin
        mul_a = xxh_pkg::rotl64(h ^ t, 11);
        mul_b = xxh_pkg::PR1;
      end
      S_AV_A: begin
        mul_a = h ^ (h >> xxh_pkg::AVAL_SHIFT_A);
        mul_b = xxh_pkg::PR2;
      end
      S_AV_B: begin
        mul_a = h ^ (h >> xxh_pkg::AVAL_SHIFT_B);
        mul_b = xxh_pkg::PR3;
      end
      default: is_mul = 1'b0;
    endcase
  end

  xxh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lane      <= xxh_pkg::LANE_INIT;
      total     <= '0;
      bufbytes  <= '0;
      i         <= '0;
      k         <= '0;
      last_pend <= 1'b0;
      out_pend  <= 1'b0;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
      // digest ready but output still held: park here until it drains
      if (out_pend && (!out_valid || out_ready)) begin
        hash      <= h ^ (h >> xxh_pkg::AVAL_SHIFT_C);
        out_valid <= 1'b1;
        out_pend  <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_pend <= last;
            if (cnt_eff != 4'd0) begin
              sbuf[bufbytes[4:3]] <= data_word & word_mask;
              bufbytes            <= fill_sum[4:0];
              total               <= total + {60'd0, cnt_eff};
            end
            if (cnt_eff != 4'd0 && fill_sum[5]) begin
              k     <= '0;
              state <= S_FOLD_A;
            end else if (last) begin
              state <= S_FIN;
            end
          end
        end
        S_FOLD_A: begin
          if (mul_done) begin
            t     <= mul_p;
            state <= S_FOLD_B;
          end
        end
        S_FOLD_B: begin
          if (mul_done) begin
            lane[k] <= mul_p;
            k       <= 2'(k + 2'd1);
            if (k == 2'd3) begin
              state <= last_pend ? S_FIN : S_IDLE;
            end else begin
              state <= S_FOLD_A;
            end
          end
        end
        S_FIN: begin
          h     <= long_path ? '0 : lane[2] + xxh_pkg::PR5;
          k     <= '0;
          state <= long_path ? S_MSUM : S_ADDT;
        end
        S_MSUM: begin
          h <= h + lane_rot;
          k <= 2'(k + 2'd1);
          if (k == 2'd3) begin
            state <= S_MRG_A;
          end
        end
        S_MRG_A: begin
          if (mul_done) begin
            t     <= mul_p;
            state <= S_MRG_B;
          end
        end
        S_MRG_B: begin
          if (mul_done) begin
            t     <= mul_p;
            state <= S_MRG_C;
          end
        end
        S_MRG_C: begin
          if (mul_done) begin
            h     <= mul_p + xxh_pkg::PR4;
            k     <= 2'(k + 2'd1);
            state <= (k == 2'd3) ? S_ADDT : S_MRG_A;
          end
        end
        S_ADDT: begin
          h     <= h + total;
          i     <= '0;
          state <= S_TAIL;
        end
        S_TAIL: begin
          if ({1'b0, i} + 6'd8 <= {1'b0, bufbytes}) begin
            state <= S_T8_A;
          end else if ({1'b0, i} + 6'd4 <= {1'b0, bufbytes}) begin
            state <= S_T4_A;
          end else if (i < bufbytes) begin
            state <= S_T1_A;
          end else begin
            state <= S_AV_A;
          end
        end
        S_T8_A: begin
          if (mul_done) begin
            t     <= mul_p;
            state <= S_T8_B;
          end
        end
        S_T8_B: begin
          if (mul_done) begin
            t     <= mul_p;
            state <= S_T8_C;
          end
        end
        S_T8_C: begin
          if (mul_done) begin
            h     <= mul_p + xxh_pkg::PR4;
            i     <= 5'(i + 5'd8);
            state <= S_TAIL;
          end
        end
        S_T4_A: begin
          if (mul_done) begin
            t     <= mul_p;
            state <= S_T4_B;
          end
        end
        S_T4_B: begin
          if (mul_done) begin
            h     <= mul_p + xxh_pkg::PR3;
            i     <= 5'(i + 5'd4);
            state <= S_TAIL;
          end
        end
        S_T1_A: begin
          if (mul_done) begin
            t     <= mul_p;
            state <= S_T1_B;
          end
        end
        S_T1_B: begin
          if (mul_done) begin
            h     <= mul_p;
            i     <= 5'(i + 5'd1);
            state <= S_TAIL;
          end
        end
        S_AV_A: begin
          if (mul_done) begin
            h     <= mul_p;
            state <= S_AV_B;
          end
        end
        S_AV_B: begin
          if (mul_done) begin
            h         <= mul_p;
            out_pend  <= 1'b1;
            lane      <= xxh_pkg::LANE_INIT;
            total     <= '0;
            bufbytes  <= '0;
            last_pend <= 1'b0;
            state     <= S_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> is_mul)
    else $error("multiplier finished outside a multiply step");

  a_out_from_digest: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(out_pend))
    else $error("digest presented without a finished hash");

  a_idle_word_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (bufbytes[2:0] == 3'd0))
    else $error("partial word left in stripe buffer while idle");

  a_tail_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAIL) |-> (i <= bufbytes))
    else $error("tail index ran past buffered bytes");

endmodule

>>> verif/xxh64_digest_checker.sv
`timescale 1ns / 1ps
module xxh64_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] hash,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned STRIPE_BYTES = 32;

  logic [63:0] lanes [xxh_pkg::NUM_LANES];
  logic [63:0] stripe [xxh_pkg::NUM_LANES];
  logic [63:0] total;
  int unsigned held;
  logic [63:0] expected_digests [$];
  logic [63:0] want;
  int          errors = 0;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    logic [127:0] d;
    d = {x, x} << r;
    return d[127:64];
  endfunction

  function automatic logic [63:0] lane_round(input logic [63:0] acc, input logic [63:0] v);
    logic [63:0] a;
    a = acc + v * xxh_pkg::PR2;
    a = rotl(a, 31);
    return a * xxh_pkg::PR1;
  endfunction

  function automatic logic [63:0] compute_digest();
    logic [63:0] h;
    logic [63:0] w;
    int unsigned i;
    i = 0;
    if (total >= 64'(STRIPE_BYTES)) begin
      h = rotl(lanes[0], 1) + rotl(lanes[1], 7) + rotl(lanes[2], 12) + rotl(lanes[3], 18);
      for (int k = 0; k < xxh_pkg::NUM_LANES; k++) begin
        h = h ^ lane_round(64'd0, lanes[k]);
        h = h * xxh_pkg::PR1 + xxh_pkg::PR4;
      end
    end else begin
      h = lanes[2] + xxh_pkg::PR5;
    end
    h = h + total;
    while (i + 8 <= held) begin
      h = h ^ lane_round(64'd0, stripe[(i >> 3) & 3]);
      h = rotl(h, 27) * xxh_pkg::PR1 + xxh_pkg::PR4;
      i += 8;
    end
    if (i + 4 <= held) begin
      w = {32'd0, stripe[(i >> 3) & 3][31:0]};
      h = h ^ (w * xxh_pkg::PR1);
      h = rotl(h, 23) * xxh_pkg::PR2 + xxh_pkg::PR3;
      i += 4;
    end
    while (i < held) begin
      w = (stripe[(i >> 3) & 3] >> ((i & 7) * 8)) & 64'hFF;
      h = h ^ (w * xxh_pkg::PR5);
      h = rotl(h, 11) * xxh_pkg::PR1;
      i++;
    end
    h = h ^ (h >> xxh_pkg::AVAL_SHIFT_A);
    h = h * xxh_pkg::PR2;
    h = h ^ (h >> xxh_pkg::AVAL_SHIFT_B);
    h = h * xxh_pkg::PR3;
    h = h ^ (h >> xxh_pkg::AVAL_SHIFT_C);
    return h;
  endfunction

  task automatic clear_state();
    for (int k = 0; k < xxh_pkg::NUM_LANES; k++) begin
      lanes[k] = xxh_pkg::LANE_INIT[k];
      stripe[k] = '0;
    end
    total = '0;
    held = 0;
  endtask

  task automatic absorb(input logic [63:0] word, input logic [3:0] count, input logic is_last);
    int unsigned n;
    logic [63:0] w;
    n = count;
    if (!is_last || n > 8) n = 8;
    w = word;
    if (n < 8) w = word & ((64'd1 << (n * 8)) - 64'd1);
    if (n > 0) begin
      stripe[(held >> 3) & 3] = w;
      held += n;
      total = total + 64'(n);
      if (held >= STRIPE_BYTES) begin
        for (int k = 0; k < xxh_pkg::NUM_LANES; k++) lanes[k] = lane_round(lanes[k], stripe[k]);
        held = 0;
      end
    end
    if (is_last) begin
      expected_digests.push_back(compute_digest());
      clear_state();
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_val);
    $display("%0t digest checker: %s: got %h want %h", $time, what, got, exp_val);
    errors++;
    fail_count <= errors;
  endtask

  initial clear_state();

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_digests.delete();
    end else begin
      if (in_valid && in_ready) absorb(data_word, byte_count, last);
      if (out_valid && out_ready) begin
        if (expected_digests.size() == 0) begin
          report("digest with no message pending", hash, '0);
        end else begin
          want = expected_digests.pop_front();
          if (hash !== want) report("digest mismatch", hash, want);
        end
      end
    end
    pending <= expected_digests.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int ITEM_GOAL    = 1550;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [63:0] data_word = '0;
  logic [3:0]  byte_count = '0;
  logic        last = 1'b0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [63:0] hash;

  logic rx_stall = 1'b0;
  logic hold_go = 1'b0;
  bit   tx_gaps = 1'b0;
  int   hold_count = 0;
  int   quiet_cycles = 0;
  int   items_sent = 0;
  int   fail_count;
  int   pending;
  int   nwords;

  xxh64_stream_hash DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_word (data_word),
    .byte_count(byte_count),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash      (hash)
  );

  xxh64_digest_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_word (data_word),
    .byte_count(byte_count),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash      (hash),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: long hold-off once requested, else random or no backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_go && hold_count < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (rx_stall) begin
      out_ready <= ($urandom_range(99) >= 30);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] random_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(input logic [63:0] d, input logic [3:0] cnt, input logic is_last);
    while (tx_gaps && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= d;
    byte_count <= cnt;
    last       <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(input int words);
    for (int k = 0; k < words; k++)
      send_word(random_word(), ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'd8, 1'b0);
    send_word(random_word(),
              ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8)),
              1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // count above eight on the last word, all ones
    send_word('1, 4'd15, 1'b1);
    // empty message
    send_word('0, 4'd0, 1'b1);
    // byte steps only
    send_word(64'h0123_4567_89AB_CDEF, 4'd3, 1'b1);
    // count ignored on a non-last word; 8-byte and 4-byte tail steps
    send_word('1, 4'd0, 1'b0);
    send_word('1, 4'd4, 1'b1);
    // last word completes a stripe
    repeat (3) send_word(random_word(), 4'd8, 1'b0);
    send_word('1, 4'd8, 1'b1);
    // 31 bytes, bytes above the count ignored
    repeat (3) send_word('1, 4'd8, 1'b0);
    send_word('1, 4'd7, 1'b1);
    // 36 bytes: lane merge plus 4-byte step
    send_word('0, 4'd15, 1'b0);
    repeat (3) send_word('1, 4'd8, 1'b0);
    send_word(64'hFEDC_BA98_7654_3210, 4'd4, 1'b1);
    // full stripe then empty last word
    repeat (4) send_word(random_word(), 4'd8, 1'b0);
    send_word('1, 4'd0, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      tx_gaps = (items_sent >= 350 && items_sent < 1200) || items_sent >= 1400;
      rx_stall <= items_sent >= 350 && items_sent < 1300;
      if (!hold_go && items_sent >= 700) begin
        hold_go <= 1'b1;
        repeat (40) send_word(random_word(), 4'($urandom_range(8)), 1'b1);
      end else begin
        nwords = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(9);
        send_message(nwords);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
